// ----- hw/rtl/ehd_pkg.sv -----
// ----------------------------------------------------------------------------
// ehd_pkg
// Shared widths, constants and register indexes of the hysteresis debouncer.
// ----------------------------------------------------------------------------
package ehd_pkg;

    localparam int Y_W      = 16;   // Q0.16 integrator
    localparam int DT_W     = 16;   // elapsed microseconds per sample
    localparam int DECAY_W  = 24;   // decay time constant
    localparam int DEN_W    = 25;   // decay + elapsed
    localparam int COUNT_W  = 42;   // microsecond counter
    localparam int MS_W     = 32;   // reported milliseconds
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [Y_W-1:0]     FULL_SCALE     = 16'hFFFF;
    localparam logic [Y_W-1:0]     LOW_THRESHOLD  = 16'd16384;
    localparam logic [Y_W-1:0]     HIGH_THRESHOLD = 16'd49152;
    localparam logic [COUNT_W-1:0] COUNT_MAX      = {COUNT_W{1'b1}};
    localparam logic [DECAY_W-1:0] DECAY_RESET    = 24'd20000;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_US = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INVERT   = 2'd1;

endpackage

// ----- hw/rtl/ehd_in_if.sv -----
// ----------------------------------------------------------------------------
// ehd_in_if
// Sample channel: raw pin level and elapsed microseconds.
// ----------------------------------------------------------------------------
interface ehd_in_if;
    logic                     valid;
    logic                     ready;
    logic                     pin_level;
    logic [ehd_pkg::DT_W-1:0] elapsed_us;

    modport source (output valid, output pin_level, output elapsed_us, input ready);
    modport sink   (input valid, input pin_level, input elapsed_us, output ready);
endinterface

// ----- hw/rtl/ehd_out_if.sv -----
// ----------------------------------------------------------------------------
// ehd_out_if
// Result channel: debounced level, edge flags, time since last change.
// ----------------------------------------------------------------------------
interface ehd_out_if;
    logic                     valid;
    logic                     ready;
    logic                     is_on;
    logic                     went_on;
    logic                     went_off;
    logic [ehd_pkg::MS_W-1:0] ms_since_change;

    modport source (output valid, output is_on, output went_on, output went_off,
                    output ms_since_change, input ready);
    modport sink   (input valid, input is_on, input went_on, input went_off,
                    input ms_since_change, output ready);
endinterface

// ----- hw/rtl/ehd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// ehd_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface ehd_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ehd_pkg::CFG_IDX_W-1:0]  index;
    logic [ehd_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/ehd_step_calc.sv -----
// ----------------------------------------------------------------------------
// ehd_step_calc
// Serial step = mag * dt / (decay + dt): shift-add multiply, then restoring
// divide, both sharing one 41-bit shift register.
// ----------------------------------------------------------------------------
module ehd_step_calc (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [ehd_pkg::Y_W-1:0]     i_mag,
    input  logic [ehd_pkg::DT_W-1:0]    i_dt,
    input  logic [ehd_pkg::DECAY_W-1:0] i_decay,
    output logic                        o_done,
    output logic [ehd_pkg::Y_W-1:0]     o_step
);

    localparam int STEPS = ehd_pkg::Y_W;
    localparam int CNT_W = $clog2(STEPS);

    typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} t_state;

    t_state                       r_state;
    logic [CNT_W-1:0]             r_cnt;
    logic [ehd_pkg::DEN_W-1:0]    r_hi;     // product high half, then remainder
    logic [ehd_pkg::Y_W-1:0]      r_lo;     // multiplier, then quotient
    logic [ehd_pkg::Y_W-1:0]      r_mag;
    logic [ehd_pkg::DEN_W-1:0]    r_den;
    logic                         r_done;
    logic [ehd_pkg::Y_W-1:0]      r_step;

    logic [ehd_pkg::Y_W:0]        mul_sum;
    logic [ehd_pkg::DEN_W:0]      div_trial;
    logic [ehd_pkg::DEN_W:0]      div_diff;
    logic                         div_ge;
    logic                         last;

    assign mul_sum   = {1'b0, r_hi[ehd_pkg::Y_W-1:0]} + (r_lo[0] ? {1'b0, r_mag} : '0);
    assign div_trial = {r_hi, r_lo[ehd_pkg::Y_W-1]};
    assign div_diff  = div_trial - {1'b0, r_den};
    assign div_ge    = (div_trial >= {1'b0, r_den});
    assign last      = (r_cnt == CNT_W'(STEPS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_hi    <= '0;
                        r_lo    <= i_dt;
                        r_mag   <= i_mag;
                        r_den   <= {1'b0, i_decay} + ehd_pkg::DEN_W'(i_dt);
                        r_cnt   <= '0;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_hi  <= ehd_pkg::DEN_W'(mul_sum[ehd_pkg::Y_W:1]);
                    r_lo  <= {mul_sum[0], r_lo[ehd_pkg::Y_W-1:1]};
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_hi  <= div_ge ? div_diff[ehd_pkg::DEN_W-1:0]
                                    : div_trial[ehd_pkg::DEN_W-1:0];
                    r_lo  <= {r_lo[ehd_pkg::Y_W-2:0], div_ge};
                    r_cnt <= r_cnt + 1'b1;
                    if (last) begin
                        // zero denominator means zero elapsed time: hold
                        r_step  <= (r_den == '0) ? '0 : {r_lo[ehd_pkg::Y_W-2:0], div_ge};
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_step = r_step;

endmodule

// ----- hw/rtl/ehd_ms_div.sv -----
// ----------------------------------------------------------------------------
// ehd_ms_div
// Microseconds to milliseconds: restoring divide by 1000, two quotient bits
// per cycle, saturated to 32 bits.
// ----------------------------------------------------------------------------
module ehd_ms_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [ehd_pkg::COUNT_W-1:0]   i_count,
    output logic                          o_done,
    output logic [ehd_pkg::MS_W-1:0]      o_ms
);

    localparam int REM_W = 10;
    localparam int STEPS = (ehd_pkg::COUNT_W + 1) / 2;
    localparam int CNT_W = $clog2(STEPS);
    localparam logic [REM_W:0] DIVISOR = 11'd1000;

    typedef enum logic {S_IDLE, S_RUN} t_state;

    t_state                         r_state;
    logic [CNT_W-1:0]               r_cnt;
    logic [REM_W-1:0]               r_rem;
    logic [ehd_pkg::COUNT_W-1:0]    r_num;  // dividend out at top, quotient in at bottom
    logic                           r_done;
    logic [ehd_pkg::MS_W-1:0]       r_ms;

    logic [REM_W:0]                 dig1;
    logic [REM_W:0]                 dig2;
    logic [ehd_pkg::COUNT_W-1:0]    quot;

    // one restoring digit: {quotient bit, new remainder}
    function automatic logic [REM_W:0] digit(input logic [REM_W-1:0] rem, input logic din);
        logic [REM_W:0] t;
        t = {rem, din};
        if (t >= DIVISOR) begin
            return {1'b1, REM_W'(t - DIVISOR)};
        end
        return {1'b0, t[REM_W-1:0]};
    endfunction

    assign dig1 = digit(r_rem, r_num[ehd_pkg::COUNT_W-1]);
    assign dig2 = digit(dig1[REM_W-1:0], r_num[ehd_pkg::COUNT_W-2]);
    assign quot = {r_num[ehd_pkg::COUNT_W-3:0], dig1[REM_W], dig2[REM_W]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_rem   <= '0;
                        r_num   <= i_count;
                        r_cnt   <= '0;
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    r_rem <= dig2[REM_W-1:0];
                    r_num <= quot;
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(STEPS - 1)) begin
                        r_ms    <= (|quot[ehd_pkg::COUNT_W-1:ehd_pkg::MS_W])
                                   ? '1 : quot[ehd_pkg::MS_W-1:0];
                        r_done  <= 1'b1;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_ms   = r_ms;

endmodule

// ----- hw/rtl/exponential_hysteresis_debouncer_core.sv -----
// ----------------------------------------------------------------------------
// exponential_hysteresis_debouncer_core
// Integrating pin debouncer with hysteresis and time-since-change report.
// ----------------------------------------------------------------------------
// Usage:
//   i_in   : one item per raw pin sample (pin_level, elapsed_us).
//   o_out  : one item per sample (is_on, went_on, went_off, ms_since_change).
//   i_cfg  : register writes, always ready; index 0 decay_us, 1 invert.
//            Write only while no sample is in flight.
// Flow:
//   The first sample after reset loads the integrator from the pin and
//   goes straight to S_DONE, bypassing the step unit and the ms divider.
//   Every later sample waits in S_CALC: the step unit does a shift-add
//   multiply then a restoring divide; the ms divider (2 bits per cycle)
//   runs alongside. One sample is in work at a time, so the next one is
//   accepted only once the last has left S_DONE for the output register.
// Reset: decay_us 20000, invert 0, integrator and counter cleared; the
//   next sample primes the state.
// Stall: the result sits in the output register until taken; the next
//   sample is accepted and computed meanwhile, then waits for the register.
// ----------------------------------------------------------------------------
module exponential_hysteresis_debouncer_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ehd_in_if.sink     i_in,
    ehd_out_if.source  o_out,
    ehd_cfg_if.sink    i_cfg
);

    typedef enum logic [1:0] {S_IDLE, S_CALC, S_DONE} t_state;

    t_state                          r_state;
    logic [ehd_pkg::DECAY_W-1:0]     r_decay;
    logic                            r_invert;
    logic [ehd_pkg::Y_W-1:0]         r_y;
    logic                            r_level;
    logic                            r_primed;
    logic [ehd_pkg::COUNT_W-1:0]     r_us;
    logic                            r_pin;
    logic                            r_wait_step;
    logic                            r_wait_ms;
    logic                            r_flip;
    logic [ehd_pkg::MS_W-1:0]        r_res_ms;

    logic                            r_out_valid;
    logic                            r_out_is_on;
    logic                            r_out_went_on;
    logic                            r_out_went_off;
    logic [ehd_pkg::MS_W-1:0]        r_out_ms;

    logic                            in_acc;
    logic                            start;
    logic [ehd_pkg::Y_W-1:0]         mag;
    logic [ehd_pkg::COUNT_W:0]       us_sum;
    logic [ehd_pkg::COUNT_W-1:0]     us_sat;
    logic                            step_done;
    logic [ehd_pkg::Y_W-1:0]         step;
    logic                            ms_done;
    logic [ehd_pkg::MS_W-1:0]        ms_val;
    logic [ehd_pkg::Y_W-1:0]         y_new;
    logic                            level_new;
    logic                            out_free;
    logic                            on_now;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_acc      = i_in.valid && (r_state == S_IDLE);
    assign start       = in_acc && r_primed;

    // distance to target: full scale for a high pin, zero for a low pin
    assign mag    = i_in.pin_level ? (ehd_pkg::FULL_SCALE - r_y) : r_y;
    assign us_sum = {1'b0, r_us} + (ehd_pkg::COUNT_W+1)'(i_in.elapsed_us);
    assign us_sat = us_sum[ehd_pkg::COUNT_W] ? ehd_pkg::COUNT_MAX
                                             : us_sum[ehd_pkg::COUNT_W-1:0];

    ehd_step_calc u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_mag   (mag),
        .i_dt    (i_in.elapsed_us),
        .i_decay (r_decay),
        .o_done  (step_done),
        .o_step  (step)
    );

    ehd_ms_div u_ms (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_count (us_sat),
        .o_done  (ms_done),
        .o_ms    (ms_val)
    );

    assign y_new     = r_pin ? (r_y + step) : (r_y - step);
    assign level_new = r_level ? (y_new > ehd_pkg::LOW_THRESHOLD)
                               : (y_new > ehd_pkg::HIGH_THRESHOLD);
    assign out_free  = !r_out_valid || o_out.ready;
    assign on_now    = r_level ^ r_invert;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay  <= ehd_pkg::DECAY_RESET;
            r_invert <= 1'b0;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                ehd_pkg::REG_DECAY_US: r_decay  <= i_cfg.data;
                ehd_pkg::REG_INVERT:   r_invert <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_y         <= '0;
            r_level     <= 1'b0;
            r_primed    <= 1'b0;
            r_us        <= '0;
            r_wait_step <= 1'b0;
            r_wait_ms   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if ((r_state == S_DONE) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_pin <= i_in.pin_level;
                        if (!r_primed) begin
                            r_y      <= i_in.pin_level ? ehd_pkg::FULL_SCALE : '0;
                            r_level  <= i_in.pin_level;
                            r_us     <= '0;
                            r_primed <= 1'b1;
                            r_flip   <= 1'b0;
                            r_res_ms <= '0;
                            r_state  <= S_DONE;
                        end else begin
                            r_us        <= us_sat;
                            r_wait_step <= 1'b1;
                            r_wait_ms   <= 1'b1;
                            r_state     <= S_CALC;
                        end
                    end
                end
                S_CALC: begin
                    if (step_done) begin
                        r_wait_step <= 1'b0;
                    end
                    if (ms_done) begin
                        r_wait_ms <= 1'b0;
                        r_res_ms  <= ms_val;
                    end
                    if (!r_wait_step && !r_wait_ms) begin
                        r_y     <= y_new;
                        r_level <= level_new;
                        r_flip  <= (level_new != r_level);
                        if (level_new != r_level) begin
                            r_us <= '0;
                        end
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_out_is_on    <= on_now;
                        r_out_went_on  <= r_flip && on_now;
                        r_out_went_off <= r_flip && !on_now;
                        r_out_ms       <= r_flip ? '0 : r_res_ms;
                        r_state        <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.is_on           = r_out_is_on;
    assign o_out.went_on         = r_out_went_on;
    assign o_out.went_off        = r_out_went_off;
    assign o_out.ms_since_change = r_out_ms;

endmodule

// ----- tb/ehd_level_checker.sv -----
// ----------------------------------------------------------------------------
// ehd_level_checker
// Watches the sample, result and register channels of the debouncer, keeps
// its own integrator / level / counter state and compares every result item
// field by field against the oldest predicted one.
// ----------------------------------------------------------------------------
module ehd_level_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ehd_in_if    i_sample,
    ehd_out_if   i_report,
    ehd_cfg_if   i_cfg,
    output int   o_errors,
    output int   o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SUM_W = ehd_pkg::COUNT_W + 1;

    typedef struct packed {
        logic                     is_on;
        logic                     went_on;
        logic                     went_off;
        logic [ehd_pkg::MS_W-1:0] ms_since_change;
    } t_level_report;

    // shadow registers and debouncer state
    logic [ehd_pkg::DECAY_W-1:0] decay_us_q;
    logic                        invert_q;
    logic [ehd_pkg::Y_W-1:0]     integ;
    logic                        level;
    logic                        primed;
    logic [ehd_pkg::COUNT_W-1:0] us_count;

    t_level_report level_reports_q[$];
    int            mismatches  = 0;
    int            outstanding = 0;

    assign o_errors      = mismatches;
    assign o_outstanding = outstanding;

    task automatic flag_mismatch(input string what);
        $display("MISMATCH @%0t ns: %s", $realtime, what);
        mismatches++;
    endtask

    // Advance the integrator by one sample and build the result it produces.
    task automatic debounce_sample(input logic pin, input logic [ehd_pkg::DT_W-1:0] dt,
                                   output t_level_report r);
        logic [ehd_pkg::Y_W-1:0]     target;
        logic [ehd_pkg::DEN_W-1:0]   den;
        logic [ehd_pkg::Y_W-1:0]     mag;
        logic [63:0]                 step;
        logic                        next_level;
        logic [SUM_W-1:0]            sum;
        logic [ehd_pkg::COUNT_W-1:0] ms_full;
        target = pin ? ehd_pkg::FULL_SCALE : '0;
        r = '0;
        if (!primed) begin
            // first item after reset loads integrator and level from the pin, clears the counter
            integ    = target;
            level    = pin;
            us_count = '0;
            primed   = 1'b1;
        end else begin
            den = ehd_pkg::DEN_W'(decay_us_q) + ehd_pkg::DEN_W'(dt);
            if (den != '0) begin
                mag   = (target >= integ) ? target - integ : integ - target;
                step  = (64'(mag) * 64'(dt)) / 64'(den);
                integ = (target >= integ) ? integ + step[ehd_pkg::Y_W-1:0]
                                          : integ - step[ehd_pkg::Y_W-1:0];
            end
            next_level = level ? (integ > ehd_pkg::LOW_THRESHOLD)
                               : (integ > ehd_pkg::HIGH_THRESHOLD);
            sum        = SUM_W'(us_count) + SUM_W'(dt);
            us_count   = (sum > SUM_W'(ehd_pkg::COUNT_MAX)) ? ehd_pkg::COUNT_MAX
                                                            : sum[ehd_pkg::COUNT_W-1:0];
            if (next_level != level) begin
                level    = next_level;
                us_count = '0;
                if (next_level ^ invert_q) r.went_on = 1'b1;
                else r.went_off = 1'b1;
            end
        end
        ms_full = us_count / ehd_pkg::COUNT_W'(1000);
        r.ms_since_change = (ms_full > ehd_pkg::COUNT_W'({ehd_pkg::MS_W{1'b1}}))
                            ? '1 : ms_full[ehd_pkg::MS_W-1:0];
        r.is_on = level ^ invert_q;
    endtask

    always @(posedge i_clk) begin
        t_level_report want;
        if (!i_rst_n) begin
            decay_us_q = ehd_pkg::DECAY_RESET;
            invert_q   = 1'b0;
            integ      = '0;
            level      = 1'b0;
            primed     = 1'b0;
            us_count   = '0;
            level_reports_q.delete();
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                if (i_cfg.index == ehd_pkg::REG_DECAY_US)
                    decay_us_q = i_cfg.data[ehd_pkg::DECAY_W-1:0];
                else if (i_cfg.index == ehd_pkg::REG_INVERT)
                    invert_q = i_cfg.data[0];
            end
            if (i_sample.valid && i_sample.ready) begin
                debounce_sample(i_sample.pin_level, i_sample.elapsed_us, want);
                level_reports_q.push_back(want);
            end
            if (i_report.valid && i_report.ready) begin
                if (level_reports_q.size() == 0) begin
                    flag_mismatch("result item with no sample outstanding");
                end else begin
                    want = level_reports_q.pop_front();
                    if (i_report.is_on !== want.is_on)
                        flag_mismatch($sformatf("is_on got %0b want %0b",
                                                i_report.is_on, want.is_on));
                    if (i_report.went_on !== want.went_on)
                        flag_mismatch($sformatf("went_on got %0b want %0b",
                                                i_report.went_on, want.went_on));
                    if (i_report.went_off !== want.went_off)
                        flag_mismatch($sformatf("went_off got %0b want %0b",
                                                i_report.went_off, want.went_off));
                    if (i_report.ms_since_change !== want.ms_since_change)
                        flag_mismatch($sformatf("ms_since_change got %0d want %0d",
                                                i_report.ms_since_change,
                                                want.ms_since_change));
                end
            end
        end
        outstanding <= level_reports_q.size();
    end

endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Stimulus for the hysteresis debouncer: a directed pass over priming, the
// hold and jump cases, inversion and the decay extremes, then random phases
// of bouncing pin traces under varied settings with bursty samples and a
// stalling result consumer. Checking is done by ehd_level_checker.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int SETTLE_CYCLES   = 60;

    localparam logic [ehd_pkg::DECAY_W-1:0]   DECAY_MAX       = '1;
    localparam logic [ehd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LO = 2'd2;
    localparam logic [ehd_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HI = 2'd3;

    typedef enum int {TAKE_ALWAYS, TAKE_RANDOM, TAKE_PERIODIC} t_take_mode;

    logic clk;
    logic rst_n;
    int   mismatches;
    int   outstanding;

    ehd_in_if  sample_ch ();
    ehd_out_if report_ch ();
    ehd_cfg_if cfg_ch ();

    exponential_hysteresis_debouncer_core u_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (sample_ch),
        .o_out   (report_ch),
        .i_cfg   (cfg_ch)
    );

    ehd_level_checker u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_sample      (sample_ch),
        .i_report      (report_ch),
        .i_cfg         (cfg_ch),
        .o_errors      (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result consumer: stall pattern re-chosen whenever the current mode runs out
    t_take_mode take_mode  = TAKE_ALWAYS;
    int         mode_left  = 0;
    int         take_period = 2;
    int         stall_len  = 1;
    int         take_tick  = 0;

    always @(posedge clk) begin
        if (mode_left == 0) begin
            take_mode   = t_take_mode'($urandom_range(0, 2));
            mode_left   = $urandom_range(100, 800);
            take_period = $urandom_range(2, 120);
            stall_len   = $urandom_range(1, take_period - 1);
            take_tick   = 0;
        end
        mode_left--;
        take_tick = (take_tick + 1) % take_period;
        case (take_mode)
            TAKE_ALWAYS: report_ch.ready <= 1'b1;
            TAKE_RANDOM: report_ch.ready <= 1'($urandom_range(0, 1));
            default:     report_ch.ready <= (take_tick >= stall_len);
        endcase
    end

    // sender and random trace state
    int   burst_left = 0;
    logic steady_pin = 1'b0;
    int   run_left   = 0;
    int   run_max    = 8;
    int   dt_cap     = 5000;

    // Offer one item; keep valid up while the burst goes on, else idle a while.
    task automatic send_sample(input logic pin, input logic [ehd_pkg::DT_W-1:0] dt);
        sample_ch.valid      <= 1'b1;
        sample_ch.pin_level  <= pin;
        sample_ch.elapsed_us <= dt;
        do @(posedge clk); while (!sample_ch.ready);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            sample_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                     : $urandom_range(0, 6);
        end
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    task automatic set_reg(input logic [ehd_pkg::CFG_IDX_W-1:0] idx,
                           input logic [ehd_pkg::CFG_DATA_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic new_setting();
        logic [ehd_pkg::DECAY_W-1:0] decay;
        case ($urandom_range(0, 5))
            0:       decay = ehd_pkg::DECAY_W'(1);
            1:       decay = DECAY_MAX;
            2:       decay = ehd_pkg::DECAY_W'($urandom_range(1, 255));
            3:       decay = ehd_pkg::DECAY_W'($urandom_range(256, 20000));
            4:       decay = ehd_pkg::DECAY_W'($urandom_range(20001, 300000));
            default: decay = ehd_pkg::DECAY_W'($urandom_range(1, 2**ehd_pkg::DECAY_W - 1));
        endcase
        set_reg(ehd_pkg::REG_DECAY_US, ehd_pkg::CFG_DATA_W'(decay));
        set_reg(ehd_pkg::REG_INVERT, ehd_pkg::CFG_DATA_W'($urandom_range(0, 1)));
        dt_cap  = (int'(decay) / 4 > 65535) ? 65535 : int'(decay) / 4 + 1;
        run_max = $urandom_range(2, 64);
    endtask

    // Pin held steady for random runs, with single-sample bounces mixed in.
    task automatic send_random_sample();
        logic                     pin;
        logic [ehd_pkg::DT_W-1:0] dt;
        int                       pick;
        if (run_left == 0) begin
            steady_pin = ~steady_pin;
            run_left   = $urandom_range(1, run_max);
        end
        run_left--;
        pin  = ($urandom_range(0, 9) == 0) ? ~steady_pin : steady_pin;
        pick = $urandom_range(0, 19);
        if (pick == 0) dt = '0;
        else if (pick == 1) dt = '1;
        else if (pick < 7) dt = ehd_pkg::DT_W'($urandom);
        else dt = ehd_pkg::DT_W'($urandom_range(0, dt_cap));
        send_sample(pin, dt);
    endtask

    initial begin
        rst_n                <= 1'b0;
        sample_ch.valid      <= 1'b0;
        sample_ch.pin_level  <= 1'b0;
        sample_ch.elapsed_us <= '0;
        cfg_ch.valid         <= 1'b0;
        cfg_ch.index         <= ehd_pkg::REG_DECAY_US;
        cfg_ch.data          <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // priming item: elapsed time is ignored
        send_sample(1'b1, '1);
        send_sample(1'b0, '0);          // no elapsed time, integrator holds
        send_sample(1'b0, '1);
        send_sample(1'b0, '1);
        send_sample(1'b1, '1);
        send_sample(1'b1, '1);
        send_sample(1'b1, 16'h5555);
        send_sample(1'b0, 16'hAAAA);
        wait_idle();

        // inversion flips is_on without an edge flag
        set_reg(ehd_pkg::REG_INVERT, ehd_pkg::CFG_DATA_W'(1));
        send_sample(1'b1, 16'd500);
        send_sample(1'b0, '1);
        send_sample(1'b0, '1);
        wait_idle();

        // zero decay: holds on zero elapsed, jumps to target otherwise
        set_reg(ehd_pkg::REG_DECAY_US, '0);
        send_sample(1'b0, '0);
        send_sample(1'b1, '0);
        send_sample(1'b1, 16'd1);
        send_sample(1'b0, 16'd1);
        wait_idle();

        set_reg(ehd_pkg::REG_DECAY_US, ehd_pkg::CFG_DATA_W'(DECAY_MAX));
        set_reg(ehd_pkg::REG_INVERT, '0);
        send_sample(1'b0, '1);
        send_sample(1'b0, '1);
        send_sample(1'b0, '1);
        send_sample(1'b1, '1);
        wait_idle();

        // writes to unmapped indexes must be ignored
        set_reg(REG_UNMAPPED_LO, ehd_pkg::CFG_DATA_W'($urandom));
        set_reg(REG_UNMAPPED_HI, '1);
        set_reg(ehd_pkg::REG_DECAY_US, ehd_pkg::CFG_DATA_W'(1));
        send_sample(1'b1, 16'd1);
        send_sample(1'b0, 16'd1);
        send_sample(1'b0, '1);
        wait_idle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            new_setting();
            repeat (ITEMS_PER_PHASE) send_random_sample();
            wait_idle();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/ehd_pkg.sv
hw/rtl/ehd_in_if.sv
hw/rtl/ehd_out_if.sv
hw/rtl/ehd_cfg_if.sv
hw/rtl/ehd_step_calc.sv
hw/rtl/ehd_ms_div.sv
hw/rtl/exponential_hysteresis_debouncer_core.sv
tb/ehd_level_checker.sv
tb/tb.sv
